[hdl/cld_pkg.sv]
// cld_pkg: shared types, codes and character constants for the
// content-length deframer. No dependencies.
package cld_pkg;

  localparam int unsigned CFG_W     = 24;
  localparam int unsigned TAG_LEN   = 15;

  localparam logic [CFG_W-1:0] MAX_LENGTH_RESET = 24'd1048576;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
    logic       failed;
  } cld_result_t;

  // "Content-Length:" one character per position
  function automatic logic [7:0] tag_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h6e; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6e; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2d; // -
      4'd8:    c = 8'h4c; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6e; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      4'd14:   c = 8'h3a; // :
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // CR LF CR LF separator
  function automatic logic [7:0] sep_char(input logic [1:0] idx);
    return idx[0] ? CHAR_LF : CHAR_CR;
  endfunction

endpackage

[hdl/cld_parser.sv]
// cld_parser: header matcher, length parser and payload counter; produces
// one result per accepted byte. Depends on cld_pkg.
module cld_parser #(
  parameter int unsigned LENGTH_WIDTH = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              in_byte_i,
  input  logic [LENGTH_WIDTH-1:0] max_length_i,
  output cld_pkg::cld_result_t    result_o
);

  localparam logic [2:0] PH_PREFIX  = 3'd0;
  localparam logic [2:0] PH_NUMBER  = 3'd1;
  localparam logic [2:0] PH_REST    = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_ERROR   = 3'd4;

  localparam int unsigned AccW = LENGTH_WIDTH + 1;
  localparam int unsigned MulW = LENGTH_WIDTH + 5;
  localparam logic [MulW-1:0] AccCap = MulW'(1) << LENGTH_WIDTH;

  logic [2:0]              phase_q, phase_d;
  logic [3:0]              pos_q, pos_d;
  logic [1:0]              sep_q, sep_d;
  logic [AccW-1:0]         acc_q, acc_d;
  logic                    digit_q, digit_d;
  logic                    bad_q, bad_d;
  logic [LENGTH_WIDTH-1:0] rem_q, rem_d;
  logic                    err_q, err_d;

  logic [MulW-1:0] acc_mul;
  logic [2:0]      sep_nx;
  logic            is_digit;

  assign is_digit = (in_byte_i >= cld_pkg::CHAR_ZERO) && (in_byte_i <= cld_pkg::CHAR_NINE);
  assign acc_mul  = {acc_q, 3'b000} + {2'b00, acc_q, 1'b0} + MulW'(in_byte_i[3:0]);
  assign sep_nx   = (in_byte_i == cld_pkg::sep_char(sep_q)) ? ({1'b0, sep_q} + 3'd1)
                  : ((in_byte_i == cld_pkg::CHAR_CR) ? 3'd1 : 3'd0);

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    sep_d    = sep_q;
    acc_d    = acc_q;
    digit_d  = digit_q;
    bad_d    = bad_q;
    rem_d    = rem_q;
    err_d    = err_q;
    result_o.kind     = cld_pkg::KIND_HEADER;
    result_o.out_byte = 8'h00;
    result_o.last     = 1'b0;

    if (accept_i) begin
      unique case (phase_q)
        PH_PAYLOAD: begin
          result_o.kind     = cld_pkg::KIND_PAYLOAD;
          result_o.out_byte = in_byte_i;
          rem_d             = rem_q - LENGTH_WIDTH'(1);
          if (rem_q == LENGTH_WIDTH'(1)) begin
            result_o.last = 1'b1;
            phase_d = PH_PREFIX;
            pos_d   = '0;
            sep_d   = '0;
            acc_d   = '0;
            digit_d = 1'b0;
            bad_d   = 1'b0;
          end
        end
        PH_PREFIX, PH_NUMBER: begin
          if (sep_q == 2'd1 && in_byte_i == cld_pkg::CHAR_LF) begin
            if (phase_q != PH_NUMBER || !digit_q) begin
              bad_d = 1'b1;
            end
            phase_d = PH_REST;
            sep_d   = 2'd2;
          end else begin
            // a lone CR counts as a line character and spoils the line
            if (sep_q == 2'd1) begin
              bad_d = 1'b1;
            end
            if (in_byte_i == cld_pkg::CHAR_CR) begin
              sep_d = 2'd1;
            end else begin
              sep_d = 2'd0;
              if (phase_q == PH_PREFIX) begin
                if (in_byte_i == cld_pkg::tag_char(pos_q)) begin
                  pos_d = pos_q + 4'd1;
                  if (pos_q == 4'(cld_pkg::TAG_LEN - 1)) begin
                    phase_d = PH_NUMBER;
                  end
                end else begin
                  bad_d = 1'b1;
                end
              end else if (in_byte_i == cld_pkg::CHAR_SPACE && !digit_q) begin
                // leading space before the number
              end else if (is_digit) begin
                digit_d = 1'b1;
                acc_d   = (acc_mul > AccCap) ? AccCap[AccW-1:0] : acc_mul[AccW-1:0];
              end else begin
                bad_d = 1'b1;
              end
            end
          end
        end
        PH_REST: begin
          sep_d = sep_nx[1:0];
          if (sep_nx == 3'd4) begin
            if (bad_q || acc_q > {1'b0, max_length_i}) begin
              err_d         = 1'b1;
              phase_d       = PH_ERROR;
              result_o.kind = cld_pkg::KIND_ERROR;
            end else if (acc_q == '0) begin
              result_o.kind = cld_pkg::KIND_EMPTY;
              result_o.last = 1'b1;
              phase_d = PH_PREFIX;
              pos_d   = '0;
              sep_d   = '0;
              acc_d   = '0;
              digit_d = 1'b0;
              bad_d   = 1'b0;
            end else begin
              rem_d   = acc_q[LENGTH_WIDTH-1:0];
              phase_d = PH_PAYLOAD;
              sep_d   = '0;
            end
          end
        end
        PH_ERROR: begin
          err_d = 1'b1;
        end
        default: begin
          phase_d = PH_ERROR;
          err_d   = 1'b1;
        end
      endcase
    end
    result_o.failed = err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      pos_q   <= '0;
      sep_q   <= '0;
      acc_q   <= '0;
      digit_q <= 1'b0;
      bad_q   <= 1'b0;
      rem_q   <= '0;
      err_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      sep_q   <= sep_d;
      acc_q   <= acc_d;
      digit_q <= digit_d;
      bad_q   <= bad_d;
      rem_q   <= rem_d;
      err_q   <= err_d;
    end
  end

endmodule

[hdl/cld_out_buf.sv]
// cld_out_buf: result register plus skid slot, decoupling the output stall
// from the input side. Depends on cld_pkg.
module cld_out_buf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cld_pkg::cld_result_t push_data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cld_pkg::cld_result_t out_data_o
);

  logic                 out_valid_q, out_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  cld_pkg::cld_result_t out_data_q, out_data_d;
  cld_pkg::cld_result_t skid_data_q, skid_data_d;
  logic                 pop;

  assign pop = out_valid_q && !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[hdl/content_length_deframer.sv]
// content_length_deframer: top level; max_length register, parser, output buffer.
// Each accepted byte's result is registered in the output register, or in the skid slot while the output stalls.
// Throughput: one byte per cycle while in_stall_o is low; the parser state updates once per accepted byte.
// in_stall_o rises only when the result register and skid slot are both full.
// Reset: parser back to prefix matching, error cleared, max_length = 1048576.
// Depends on cld_pkg, cld_parser, cld_out_buf.
module content_length_deframer #(
  parameter int unsigned LENGTH_WIDTH = 24
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [7:0]                in_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                kind_o,
  output logic [7:0]                out_byte_o,
  output logic                      last_o,
  output logic                      failed_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [cld_pkg::CFG_W-1:0] cfg_max_length_i
);

  logic [LENGTH_WIDTH-1:0] max_length_q;
  logic                    accept;
  logic                    full;
  cld_pkg::cld_result_t    result;
  cld_pkg::cld_result_t    out_data;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && !full;
  assign in_stall_o  = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_length_q <= LENGTH_WIDTH'(cld_pkg::MAX_LENGTH_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_length_q <= LENGTH_WIDTH'(cfg_max_length_i);
    end
  end

  cld_parser #(
    .LENGTH_WIDTH(LENGTH_WIDTH)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .max_length_i(max_length_q),
    .result_o    (result)
  );

  cld_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_data_i(result),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign kind_o     = out_data.kind;
  assign out_byte_o = out_data.out_byte;
  assign last_o     = out_data.last;
  assign failed_o   = out_data.failed;

endmodule
